// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the reorder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/ilr_pkg.sv =====
// Types and constants of the indexed list reorder core.
package ilr_pkg;

    localparam int ADDR_W = 10;
    localparam int LINK_DEPTH = 1 << ADDR_W;
    localparam int FUNC_W = 3;
    localparam int STATUS_W = 2;
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 24;
    localparam logic [ADDR_W-1:0] COUNT_RESET = 10'd1022;
    localparam int COUNT_CAP = 1022;

    localparam logic [FUNC_W-1:0] FN_INIT  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_AFTER = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FRONT = 3'd2;
    localparam logic [FUNC_W-1:0] FN_BACK  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_QUERY = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SELF  = 2'd2;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] S_CLEAR    = 4'd0;
    localparam logic [STEP_W-1:0] S_IDLE     = 4'd1;
    localparam logic [STEP_W-1:0] S_DISPATCH = 4'd2;
    localparam logic [STEP_W-1:0] S_Q0       = 4'd3;
    localparam logic [STEP_W-1:0] S_Q1       = 4'd4;
    localparam logic [STEP_W-1:0] S_M0       = 4'd5;
    localparam logic [STEP_W-1:0] S_M1       = 4'd6;
    localparam logic [STEP_W-1:0] S_M2       = 4'd7;
    localparam logic [STEP_W-1:0] S_M3       = 4'd8;
    localparam logic [STEP_W-1:0] S_M4       = 4'd9;
    localparam logic [STEP_W-1:0] S_M5       = 4'd10;
    localparam logic [STEP_W-1:0] S_M6       = 4'd11;
    localparam logic [STEP_W-1:0] S_M7       = 4'd12;
    localparam logic [STEP_W-1:0] S_INIT     = 4'd13;
    localparam logic [STEP_W-1:0] S_FINISH   = 4'd14;

    localparam logic [1:0] RD_NONE = 2'd0;
    localparam logic [1:0] RD_NODE = 2'd1;
    localparam logic [1:0] RD_INS  = 2'd2;
    localparam logic [1:0] RD_ANCH = 2'd3;

    localparam logic [2:0] LD_NONE = 3'd0;
    localparam logic [2:0] LD_OUTQ = 3'd1;
    localparam logic [2:0] LD_INS  = 3'd2;
    localparam logic [2:0] LD_T    = 3'd3;
    localparam logic [2:0] LD_OUTM = 3'd4;

    localparam logic [2:0] WR_NONE   = 3'd0;
    localparam logic [2:0] WR_CLEAR  = 3'd1;
    localparam logic [2:0] WR_INIT   = 3'd2;
    localparam logic [2:0] WR_UNLINK = 3'd3;
    localparam logic [2:0] WR_LINK1  = 3'd4;
    localparam logic [2:0] WR_LINK2  = 3'd5;

    localparam logic [2:0] J_NEXT     = 3'd0;
    localparam logic [2:0] J_GOTO     = 3'd1;
    localparam logic [2:0] J_ACCEPT   = 3'd2;
    localparam logic [2:0] J_DISPATCH = 3'd3;
    localparam logic [2:0] J_SWEEP    = 3'd4;
    localparam logic [2:0] J_NOT_BACK = 3'd5;
    localparam logic [2:0] J_EMIT     = 3'd6;

    localparam logic [1:0] D_FINISH = 2'd0;
    localparam logic [1:0] D_INIT   = 2'd1;
    localparam logic [1:0] D_QUERY  = 2'd2;
    localparam logic [1:0] D_MOVE   = 2'd3;

    typedef struct packed {
        logic [1:0]        rd_sel;
        logic [2:0]        ld_sel;
        logic [2:0]        wr_sel;
        logic [2:0]        jmp;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic       accept;
        logic [1:0] disp;
        logic       sweep_done;
        logic       back;
        logic       out_free;
    } cond_t;

endpackage

// ===== hw/rtl/ilr_useq.sv =====
// Microcode sequencer of the indexed list reorder core: step counter and control store.
module ilr_useq (
    input  logic            aclk,
    input  logic            aresetn,
    input  ilr_pkg::cond_t  cond,
    output ilr_pkg::ctrl_t  ctrl
);
    import ilr_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '{RD_NONE, LD_NONE, WR_NONE, J_NEXT, S_IDLE};
        unique case (step)
            S_CLEAR:    w = '{RD_NONE, LD_NONE, WR_CLEAR,  J_SWEEP,    S_IDLE};
            S_IDLE:     w = '{RD_NONE, LD_NONE, WR_NONE,   J_ACCEPT,   S_IDLE};
            S_DISPATCH: w = '{RD_NONE, LD_NONE, WR_NONE,   J_DISPATCH, S_IDLE};
            S_Q0:       w = '{RD_NODE, LD_NONE, WR_NONE,   J_NEXT,     S_IDLE};
            S_Q1:       w = '{RD_NONE, LD_OUTQ, WR_NONE,   J_GOTO,     S_FINISH};
            S_M0:       w = '{RD_NODE, LD_NONE, WR_NONE,   J_NEXT,     S_IDLE};
            S_M1:       w = '{RD_NONE, LD_NONE, WR_UNLINK, J_NEXT,     S_IDLE};
            S_M2:       w = '{RD_INS,  LD_NONE, WR_NONE,   J_NEXT,     S_IDLE};
            S_M3:       w = '{RD_NONE, LD_INS,  WR_NONE,   J_NOT_BACK, S_M6};
            S_M4:       w = '{RD_ANCH, LD_NONE, WR_NONE,   J_NEXT,     S_IDLE};
            S_M5:       w = '{RD_NONE, LD_T,    WR_NONE,   J_NEXT,     S_IDLE};
            S_M6:       w = '{RD_NONE, LD_NONE, WR_LINK1,  J_NEXT,     S_IDLE};
            S_M7:       w = '{RD_NONE, LD_OUTM, WR_LINK2,  J_GOTO,     S_FINISH};
            S_INIT:     w = '{RD_NONE, LD_NONE, WR_INIT,   J_SWEEP,    S_FINISH};
            S_FINISH:   w = '{RD_NONE, LD_NONE, WR_NONE,   J_EMIT,     S_IDLE};
            default:    w = '{RD_NONE, LD_NONE, WR_NONE,   J_GOTO,     S_IDLE};
        endcase
        return w;
    endfunction

    assign ctrl = ucode(step_reg);

    always_comb begin
        step_next = step_reg + 1'b1;
        unique case (ctrl.jmp)
            J_NEXT:     step_next = step_reg + 1'b1;
            J_GOTO:     step_next = ctrl.target;
            J_ACCEPT:   step_next = cond.accept ? S_DISPATCH : step_reg;
            J_SWEEP:    step_next = cond.sweep_done ? (step_reg + 1'b1) : step_reg;
            J_NOT_BACK: step_next = cond.back ? (step_reg + 1'b1) : ctrl.target;
            J_EMIT:     step_next = cond.out_free ? ctrl.target : step_reg;
            J_DISPATCH: begin
                unique case (cond.disp)
                    D_FINISH: step_next = S_FINISH;
                    D_INIT:   step_next = S_INIT;
                    D_QUERY:  step_next = S_Q0;
                    D_MOVE:   step_next = S_M0;
                    default:  step_next = S_FINISH;
                endcase
            end
            default:    step_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= S_CLEAR;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== hw/rtl/indexed_list_reorder_core.sv =====
// Top level of the indexed list reorder core: link memories, datapath and ports.

// Ordered list of entries 1..count held as a doubly linked list in two 1024 x 10
// link memories, head sentinel 0 and tail sentinel count+1. A microcoded sequencer
// runs one item at a time over the single read and write port of each memory.
// Input word: tuser = func; tdata = node [9:0], anchor [19:10]. Result word:
// tdata = status [1:0], next_node [11:2], prev_node [21:12]. A query reads the node's
// links; a move, a chain of dependent link reads and writes, unlinks the node, reads
// the insertion point (for a move to the back also the entry before the tail) and
// links the node in; a rejected request goes straight to the result. A stalled result
// word holds the sequencer. After reset a clearing pass rebuilds the list over all
// 1024 entries, during which no word is accepted; the count register can be written
// at any time and takes effect at the next accepted word.
`include "assert_macros.svh"

module indexed_list_reorder_core #(
    parameter int MAX_ENTRIES = 1022
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data,     // car_count [9:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,      // node [9:0], anchor [19:10], zero [23:20]
    input  logic [2:0]  s_tuser,      // func [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata       // status [1:0], next_node [11:2], prev_node [21:12]
);
    import ilr_pkg::*;

    localparam logic [ADDR_W-1:0] COUNT_LIMIT =
        ADDR_W'((MAX_ENTRIES < COUNT_CAP) ? MAX_ENTRIES : COUNT_CAP);

    ctrl_t ctrl;
    cond_t cond;

    logic [ADDR_W-1:0] next_mem [LINK_DEPTH];
    logic [ADDR_W-1:0] prev_mem [LINK_DEPTH];

    logic [ADDR_W-1:0]   car_count_reg;
    logic [ADDR_W-1:0]   eff_count;
    logic [ADDR_W-1:0]   cnt_reg;
    logic [FUNC_W-1:0]   func_reg;
    logic [ADDR_W-1:0]   node_reg;
    logic [ADDR_W-1:0]   anchor_reg;
    logic [ADDR_W-1:0]   a_reg;
    logic [ADDR_W-1:0]   t_reg;
    logic [ADDR_W-1:0]   idx_reg;
    logic [ADDR_W-1:0]   idx_next;
    logic [ADDR_W-1:0]   next_q_reg;
    logic [ADDR_W-1:0]   prev_q_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [ADDR_W-1:0]   res_next_reg;
    logic [ADDR_W-1:0]   res_prev_reg;
    logic                m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    logic                accept;
    logic [ADDR_W-1:0]   tail;
    logic [ADDR_W-1:0]   ins_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic                sweep;
    logic [ADDR_W-1:0]   sweep_end;
    logic                beyond;
    logic                node_ok;
    logic                anchor_ok;
    logic                query_bad;
    logic [1:0]          disp;
    logic                nx_we;
    logic [ADDR_W-1:0]   nx_waddr;
    logic [ADDR_W-1:0]   nx_wdata;
    logic                pv_we;
    logic [ADDR_W-1:0]   pv_waddr;
    logic [ADDR_W-1:0]   pv_wdata;

    ilr_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cond    (cond),
        .ctrl    (ctrl)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (ctrl.jmp == J_ACCEPT);
    assign accept    = s_tvalid && s_tready;
    assign eff_count = (car_count_reg > COUNT_LIMIT) ? COUNT_LIMIT : car_count_reg;
    assign tail      = cnt_reg + 1'b1;

    // request checks
    always_comb begin
        node_ok   = (node_reg != '0) && (node_reg <= cnt_reg);
        anchor_ok = (anchor_reg <= cnt_reg);
        query_bad = {1'b0, node_reg} > ({1'b0, cnt_reg} + 1'b1);
        status_next = ST_OK;
        disp        = D_FINISH;
        priority if (func_reg == FN_INIT) begin
            disp = D_INIT;
        end else if (func_reg == FN_AFTER || func_reg == FN_FRONT || func_reg == FN_BACK) begin
            priority if (!node_ok || (func_reg == FN_AFTER && !anchor_ok)) begin
                status_next = ST_RANGE;
            end else if (func_reg == FN_AFTER && node_reg == anchor_reg) begin
                status_next = ST_SELF;
            end else begin
                disp = D_MOVE;
            end
        end else if (func_reg == FN_QUERY) begin
            if (query_bad) begin
                status_next = ST_RANGE;
            end else begin
                disp = D_QUERY;
            end
        end else begin
            status_next = ST_RANGE;
        end
    end

    always_comb begin
        priority if (func_reg == FN_AFTER) begin
            ins_addr = anchor_reg;
        end else if (func_reg == FN_FRONT) begin
            ins_addr = '0;
        end else begin
            ins_addr = tail;
        end
    end

    always_comb begin
        unique case (ctrl.rd_sel)
            RD_NODE: rd_addr = node_reg;
            RD_INS:  rd_addr = ins_addr;
            RD_ANCH: rd_addr = a_reg;
            default: rd_addr = node_reg;
        endcase
    end

    // sweep: chained values up to the tail, zero past it
    assign sweep     = (ctrl.wr_sel == WR_CLEAR) || (ctrl.wr_sel == WR_INIT);
    assign sweep_end = (ctrl.wr_sel == WR_CLEAR) ? '1 : tail;
    assign beyond    = idx_reg > tail;
    assign idx_next  = sweep ? (idx_reg + 1'b1) : '0;

    always_comb begin
        nx_we    = 1'b0;
        nx_waddr = idx_reg;
        nx_wdata = '0;
        pv_we    = 1'b0;
        pv_waddr = idx_reg;
        pv_wdata = '0;
        unique case (ctrl.wr_sel)
            WR_CLEAR, WR_INIT: begin
                nx_we    = 1'b1;
                pv_we    = 1'b1;
                nx_wdata = beyond ? '0 : ((idx_reg == tail) ? tail : (idx_reg + 1'b1));
                pv_wdata = (beyond || idx_reg == '0) ? '0 : (idx_reg - 1'b1);
            end
            WR_UNLINK: begin
                nx_we    = 1'b1;
                nx_waddr = prev_q_reg;
                nx_wdata = next_q_reg;
                pv_we    = 1'b1;
                pv_waddr = next_q_reg;
                pv_wdata = prev_q_reg;
            end
            WR_LINK1: begin
                nx_we    = 1'b1;
                nx_waddr = a_reg;
                nx_wdata = node_reg;
                pv_we    = 1'b1;
                pv_waddr = t_reg;
                pv_wdata = node_reg;
            end
            WR_LINK2: begin
                nx_we    = 1'b1;
                nx_waddr = node_reg;
                nx_wdata = t_reg;
                pv_we    = 1'b1;
                pv_waddr = node_reg;
                pv_wdata = a_reg;
            end
            default: begin
                nx_we = 1'b0;
                pv_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (nx_we) begin
            next_mem[nx_waddr] <= nx_wdata;
        end
        if (pv_we) begin
            prev_mem[pv_waddr] <= pv_wdata;
        end
        if (ctrl.rd_sel != RD_NONE) begin
            next_q_reg <= next_mem[rd_addr];
            prev_q_reg <= prev_mem[rd_addr];
        end
    end

    always_comb begin
        cond.accept     = accept;
        cond.disp       = disp;
        cond.sweep_done = (idx_reg == sweep_end);
        cond.back       = (func_reg == FN_BACK);
        cond.out_free   = !m_valid_reg || m_tready;
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg     <= s_tuser;
            node_reg     <= s_tdata[9:0];
            anchor_reg   <= s_tdata[19:10];
            res_next_reg <= '0;
            res_prev_reg <= '0;
        end
        if (ctrl.jmp == J_DISPATCH) begin
            status_reg <= status_next;
        end
        unique case (ctrl.ld_sel)
            LD_OUTQ: begin
                res_next_reg <= next_q_reg;
                res_prev_reg <= prev_q_reg;
            end
            LD_INS: begin
                a_reg <= cond.back ? prev_q_reg : ins_addr;
                t_reg <= next_q_reg;
            end
            LD_T: begin
                t_reg <= next_q_reg;
            end
            LD_OUTM: begin
                res_next_reg <= t_reg;
                res_prev_reg <= a_reg;
            end
            default: begin
            end
        endcase
        if (ctrl.jmp == J_EMIT && cond.out_free) begin
            m_data_reg <= {(OUT_DATA_W - STATUS_W - 2 * ADDR_W)'(0),
                           res_prev_reg, res_next_reg, status_reg};
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            car_count_reg <= COUNT_RESET;
            cnt_reg       <= (COUNT_RESET > COUNT_LIMIT) ? COUNT_LIMIT : COUNT_RESET;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                car_count_reg <= cfg_data;
            end
            if (accept) begin
                cnt_reg <= eff_count;
            end
            idx_reg <= idx_next;
            if (ctrl.jmp == J_EMIT && cond.out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `ASSERT_NXT(a_one_item, aclk, aresetn, accept, !s_tready)
    `ASSERT_NXT(a_emit_loads, aclk, aresetn, ctrl.jmp == J_EMIT && cond.out_free, m_tvalid)
    `ASSERT_IMP(a_self_only_after, aclk, aresetn,
                ctrl.jmp == J_EMIT && status_reg == ST_SELF, func_reg == FN_AFTER)

endmodule
